### hdl/cesd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and constants of the C escape sequence decoder
// Holds the queue entry that carries one request's results from the front
// end to the back end, together with the queue sizing.
// ----------------------------------------------------------------------------
package cesd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  // One decoded request: up to two result bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic       valid0;   // 0 only for a bare end marker
    logic [7:0] byte1;    // always a real byte when two_res is set
    logic       two_res;
    logic       done;     // request closed the string
  } entry_t;

endpackage

### hdl/cesd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_front: escape decoding front end
// Accepts one raw byte per cycle while accept_i is high, tracks the escape
// state and pushes each request's results or a bare end marker to the queue.
// ----------------------------------------------------------------------------
module cesd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            string_end_i,
  output logic            push_o,
  output cesd_pkg::entry_t entry_o
);

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEscape = 2'd1,
    ModeOctal  = 2'd2,
    ModeHex    = 2'd3
  } mode_e;

  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChX      = 8'h78;

  mode_e      mode_q, mode_d;
  logic [7:0] value_q, value_d;
  logic [1:0] oct_cnt_q, oct_cnt_d;

  // Map the byte after a backslash; anything unnamed stands for itself.
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h6e:   r = 8'h0a; // n
      8'h74:   r = 8'h09; // t
      8'h72:   r = 8'h0d; // r
      8'h76:   r = 8'h0b; // v
      8'h66:   r = 8'h0c; // f
      8'h62:   r = 8'h08; // b
      8'h61:   r = 8'h07; // a
      default: r = b;
    endcase
    return r;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  logic       is_oct;
  logic [4:0] hd;
  logic       first_en, norm_en, flush_en, do_norm;
  logic [7:0] first_byte;

  assign is_oct = (in_byte_i[7:3] == 5'b00110);
  assign hd     = hex_digit(in_byte_i);

  always_comb begin
    mode_d     = mode_q;
    value_d    = value_q;
    oct_cnt_d  = oct_cnt_q;
    first_en   = 1'b0;
    first_byte = value_q;
    do_norm    = 1'b0;
    norm_en    = 1'b0;
    flush_en   = 1'b0;
    entry_o    = '0;
    push_o     = 1'b0;

    case (mode_q)
      ModeNormal: begin
        do_norm = 1'b1;
      end
      ModeEscape: begin
        mode_d = ModeNormal;
        if (in_byte_i == ChX) begin
          mode_d  = ModeHex;
          value_d = 8'd0;
        end else if (is_oct) begin
          mode_d    = ModeOctal;
          value_d   = {5'd0, in_byte_i[2:0]};
          oct_cnt_d = 2'd0;
        end else begin
          first_en   = 1'b1;
          first_byte = esc_map(in_byte_i);
        end
      end
      ModeOctal: begin
        if (is_oct && oct_cnt_q < 2'd2) begin
          value_d   = {value_q[4:0], in_byte_i[2:0]};
          oct_cnt_d = oct_cnt_q + 2'd1;
          if (oct_cnt_q == 2'd1) begin
            first_en   = 1'b1;
            first_byte = value_d;
            mode_d     = ModeNormal;
          end
        end else begin
          first_en = 1'b1;
          mode_d   = ModeNormal;
          do_norm  = 1'b1;
        end
      end
      ModeHex: begin
        if (hd[4]) begin
          value_d = {value_q[3:0], hd[3:0]};
        end else begin
          first_en = 1'b1;
          mode_d   = ModeNormal;
          do_norm  = 1'b1;
        end
      end
      default: begin
        mode_d = ModeNormal;
      end
    endcase

    if (do_norm) begin
      if (in_byte_i == ChBslash) begin
        mode_d = ModeEscape;
      end else begin
        norm_en = 1'b1;
      end
    end

    // A pending value never coexists with an earlier result of this request.
    flush_en = string_end_i && (mode_d == ModeOctal || mode_d == ModeHex);

    entry_o.done = string_end_i;
    if (first_en) begin
      entry_o.byte0   = first_byte;
      entry_o.valid0  = 1'b1;
      entry_o.byte1   = in_byte_i;
      entry_o.two_res = norm_en;
    end else if (norm_en) begin
      entry_o.byte0  = in_byte_i;
      entry_o.valid0 = 1'b1;
    end else if (flush_en) begin
      entry_o.byte0  = value_d;
      entry_o.valid0 = 1'b1;
    end
    // Bare end marker when the final byte produced nothing.
    push_o = accept_i && (first_en || norm_en || flush_en || string_end_i);

    if (string_end_i) begin
      mode_d    = ModeNormal;
      value_d   = 8'd0;
      oct_cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      value_q   <= 8'd0;
      oct_cnt_q <= 2'd0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      value_q   <= value_d;
      oct_cnt_q <= oct_cnt_d;
    end
  end

endmodule

### hdl/cesd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_queue: short result queue
// Register-based FIFO of decoded entries between front end and back end.
// ----------------------------------------------------------------------------
module cesd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cesd_pkg::entry_t entry_i,
  input  logic             pop_i,
  output cesd_pkg::entry_t entry_o,
  output logic             empty_o,
  output logic             full_o
);

  cesd_pkg::entry_t mem_q [cesd_pkg::QueueDepth];
  logic [cesd_pkg::QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [cesd_pkg::QueueCw-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == cesd_pkg::QueueCw'(cesd_pkg::QueueDepth));
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/cesd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_back: result sequencer
// Splits each queue entry into one or two result items and holds them in
// the output register until the downstream side takes them.
// ----------------------------------------------------------------------------
module cesd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cesd_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             string_done_o,
  output logic             run_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q, bvalid_d;
  logic       done_q, done_d;
  logic       last_q, last_d;
  logic       second_q, second_d;
  logic       load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    done_d   = done_q;
    last_d   = last_q;
    second_d = second_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (entry_i.two_res && !second_q) begin
          // hold the entry for its second byte
          byte_d   = entry_i.byte0;
          bvalid_d = entry_i.valid0;
          done_d   = 1'b0;
          last_d   = 1'b0;
          second_d = 1'b1;
        end else begin
          byte_d   = second_q ? entry_i.byte1 : entry_i.byte0;
          bvalid_d = second_q ? 1'b1 : entry_i.valid0;
          done_d   = entry_i.done;
          last_d   = 1'b1;
          second_d = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    done_q   <= done_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = bvalid_q ? byte_q : 8'd0;
  assign byte_valid_o  = bvalid_q;
  assign string_done_o = done_q;
  assign run_last_o    = last_q;

endmodule

### hdl/c_escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: C string escape decoder
// Streams raw escaped bytes in and C-unescaped bytes out.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle while the queue is not full; tlast
// on the input marks the final byte of a string. Each input byte yields zero,
// one or two result items, and the back end delivers one result per cycle
// while the receiver is ready. The four-entry queue between decoder and
// sequencer absorbs second results; the sequencer registers its output.
// On the output, tlast marks the final result of a string and tuser is 0 for
// a bare end marker (string ended on a dropped trailing backslash).
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // string_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic        m_axis_tuser_o,   // [0] byte_valid
  output logic        m_axis_tlast_o    // string_done
);

  cesd_pkg::entry_t push_entry, head_entry;
  logic push, pop, empty, full, accept;
  logic [7:0] out_byte;
  logic run_last;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  cesd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (s_axis_tdata_i),
    .string_end_i (s_axis_tlast_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  cesd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  cesd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_byte_o    (out_byte),
    .byte_valid_o  (m_axis_tuser_o),
    .string_done_o (m_axis_tlast_o),
    .run_last_o    (run_last)
  );

  assign m_axis_tdata_o = {7'd0, run_last, out_byte};

endmodule

### sim/cesd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_checker: result checker for the C escape sequence decoder
// Watches both stream channels. Every accepted request is decoded by a
// behavioural model of the unescaper and its results are queued. Every
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module cesd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // string_end
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] out_byte, [8] run_last, [15:9] zero
  input  logic        m_axis_tuser_i,   // [0] byte_valid
  input  logic        m_axis_tlast_i,   // string_done
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } esc_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       run_last;
  } dec_result_t;

  localparam logic [7:0] CHR_BEL = 8'h07;
  localparam logic [7:0] CHR_BS  = 8'h08;
  localparam logic [7:0] CHR_HT  = 8'h09;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_VT  = 8'h0B;
  localparam logic [7:0] CHR_FF  = 8'h0C;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam int         REPORT_LIMIT = 10;

  esc_mode_e   mode_q;
  logic [7:0]  value_q;
  logic [1:0]  oct_cnt_q;
  dec_result_t decoded_q[$];
  dec_result_t burst[2];
  int          burst_n;

  function automatic void add_result(input logic [7:0] d, input logic v);
    burst[burst_n] = '{data: v ? d : 8'h00, valid: v, done: 1'b0, run_last: 1'b0};
    burst_n++;
  endfunction

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == "\\") mode_q = MODE_ESCAPE;
    else add_result(c, 1'b1);
  endfunction

  function automatic void take_escape(input logic [7:0] c);
    mode_q = MODE_PLAIN;
    case (c)
      "n": add_result(CHR_LF, 1'b1);
      "t": add_result(CHR_HT, 1'b1);
      "r": add_result(CHR_CR, 1'b1);
      "v": add_result(CHR_VT, 1'b1);
      "f": add_result(CHR_FF, 1'b1);
      "b": add_result(CHR_BS, 1'b1);
      "a": add_result(CHR_BEL, 1'b1);
      "x": begin
        mode_q  = MODE_HEX;
        value_q = 8'h00;
      end
      "0", "1", "2", "3", "4", "5", "6", "7": begin
        mode_q    = MODE_OCTAL;
        value_q   = {5'd0, c[2:0]};
        oct_cnt_q = 2'd0;
      end
      default: add_result(c, 1'b1);
    endcase
  endfunction

  task automatic decode_request(input logic [7:0] c, input logic is_end);
    int d;
    burst_n  = 0;
    burst[0] = '0;
    burst[1] = '0;
    case (mode_q)
      MODE_PLAIN:  take_plain(c);
      MODE_ESCAPE: take_escape(c);
      MODE_OCTAL: begin
        if (c >= "0" && c <= "7" && oct_cnt_q < 2'd2) begin
          value_q = {value_q[4:0], c[2:0]};
          oct_cnt_q++;
          // third digit closes the escape at once
          if (oct_cnt_q >= 2'd2) begin
            add_result(value_q, 1'b1);
            mode_q = MODE_PLAIN;
          end
        end else begin
          add_result(value_q, 1'b1);
          mode_q = MODE_PLAIN;
          take_plain(c);
        end
      end
      default: begin
        d = hex_digit_value(c);
        if (d >= 0) begin
          value_q = {value_q[3:0], d[3:0]};
        end else begin
          add_result(value_q, 1'b1);
          mode_q = MODE_PLAIN;
          take_plain(c);
        end
      end
    endcase

    if (is_end) begin
      // flush a pending value; a lone dropped backslash still closes the string
      if (mode_q == MODE_OCTAL || mode_q == MODE_HEX) add_result(value_q, 1'b1);
      if (burst_n == 0) add_result(8'h00, 1'b0);
      burst[burst_n-1].done = 1'b1;
      mode_q    = MODE_PLAIN;
      value_q   = 8'h00;
      oct_cnt_q = 2'd0;
    end

    if (burst_n > 0) burst[burst_n-1].run_last = 1'b1;
    for (int i = 0; i < burst_n; i++) decoded_q = {decoded_q, burst[i]};
  endtask

  task automatic check_result();
    dec_result_t want;
    if (decoded_q.size() == 0) begin
      if (fail_count_o < REPORT_LIMIT)
        $display("%0t: result with nothing outstanding: tdata %04h tuser %0b tlast %0b",
                 $time, m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
      fail_count_o++;
    end else begin
      want = decoded_q.pop_front();
      if (m_axis_tdata_i[7:0] !== want.data || m_axis_tdata_i[8] !== want.run_last ||
          m_axis_tdata_i[15:9] !== 7'd0 || m_axis_tuser_i !== want.valid ||
          m_axis_tlast_i !== want.done) begin
        if (fail_count_o < REPORT_LIMIT)
          $display("%0t: expected byte %02h run_last %0b valid %0b done %0b, %s %04h %0b %0b",
                   $time, want.data, want.run_last, want.valid, want.done,
                   "got tdata/tuser/tlast", m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = MODE_PLAIN;
      value_q      = 8'h00;
      oct_cnt_q    = 2'd0;
      fail_count_o = 0;
      decoded_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) decode_request(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
    end
    pending_o = decoded_q.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the C escape sequence decoder
// Sends directed escaped strings, then random strings built from escape
// tokens, under several sender idle and receiver stall mixes, including a
// long receiver hold-off. The checker compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 420;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int          fail_count;
  int          pending;
  int          tx_idle_pct   = 0;
  int          rx_stall_pct  = 0;
  int          items_sent    = 0;
  int          quiet_cycles  = 0;
  int          hold_cnt      = 0;
  logic        hold_req      = 1'b0;
  logic        hold_seen     = 1'b0;
  logic [7:0]  str_q[$];

  string       esc_letters = "ntrvfba\\'\"?";
  string       hex_digits  = "0123456789abcdefABCDEF";
  string       directed_texts[8] = '{"\\", "\\777", "\\x4g", "\\xq", "\\7z", "\\x41",
                                     "\\n\\\\", "A"};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  c_escape_sequence_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  cesd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver: a toggle of hold_req starts a long hold-off, otherwise stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_cnt      <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Offer one request; return just after the edge that accepts it.
  task automatic send_request(input logic [7:0] c, input logic is_end);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_end;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_request(str_q[i], i == str_q.size() - 1);
  endtask

  // Hold the sender until every predicted result has been delivered.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    str_q = {str_q, b};
  endfunction

  task automatic add_random_token();
    int kind;
    int n;
    int k;
    kind = $urandom_range(99, 0);
    if (kind < 30) begin
      k = $urandom_range(126, 32);
      if (k == "\\") k = "_";
      append_byte(k[7:0]);
    end else if (kind < 40) begin
      append_byte(8'($urandom_range(255, 0)));
    end else if (kind < 55) begin
      append_byte("\\");
      append_byte(esc_letters[$urandom_range(esc_letters.len() - 1, 0)]);
    end else if (kind < 70) begin
      append_byte("\\");
      n = $urandom_range(3, 1);
      repeat (n) append_byte(8'("0" + $urandom_range(7, 0)));
    end else if (kind < 85) begin
      append_byte("\\");
      append_byte("x");
      n = $urandom_range(4, 0);
      repeat (n) append_byte(hex_digits[$urandom_range(hex_digits.len() - 1, 0)]);
    end else if (kind < 95) begin
      append_byte("\\");
      append_byte(8'($urandom_range(255, 0)));
    end else begin
      append_byte("\\");
    end
  endtask

  initial begin
    int target;
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the byte, then the escape corner cases
    str_q = {8'h00};
    send_string();
    str_q = {8'hFF};
    send_string();
    foreach (directed_texts[t]) begin
      str_q.delete();
      for (int j = 0; j < directed_texts[t].len(); j++) append_byte(directed_texts[t][j]);
      send_string();
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 81; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 81; end
        default: begin tx_idle_pct = 16; rx_stall_pct <= 16; end
      endcase
      // starve the output early on so the input backs up
      if (phase == 0) hold_req <= ~hold_req;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        str_q.delete();
        n = $urandom_range(6, 1);
        repeat (n) add_random_token();
        send_string();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/cesd_pkg.sv
hdl/cesd_front.sv
hdl/cesd_queue.sv
hdl/cesd_back.sv
hdl/c_escape_sequence_decoder.sv
sim/cesd_checker.sv
sim/tb_top.sv
